>>> hdl/oale_pkg.sv
// Shared package of the ordered array list engine.
// Holds field widths, action and status codes, controller states and the
// command and status structures between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package oale_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int ACTION_W = 4;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int FIDX_W   = 4;
  localparam int COUNT_W  = 5;

  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = ACTION_W;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = STATUS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 4'd0,
    ACT_INSERT  = 4'd1,
    ACT_REMOVE  = 4'd2,
    ACT_SEARCH  = 4'd3,
    ACT_UPDATE  = 4'd4,
    ACT_DEL_VAL = 4'd5,
    ACT_DEL_AT  = 4'd6,
    ACT_CLEAR   = 4'd7,
    ACT_REVERSE = 4'd8,
    ACT_READ    = 4'd9
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_TOOFEW   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_SCAN,
    S_SHDN,
    S_SHUP,
    S_REVB,
    S_REVC,
    S_REVD,
    S_RESULT
  } state_e;

  typedef enum logic [3:0] {
    MOP_IDLE,
    MOP_CHECK,
    MOP_FETCH,
    MOP_SCAN,
    MOP_SHDN,
    MOP_SHUP,
    MOP_REVB,
    MOP_REVC,
    MOP_REVD,
    MOP_RESULT
  } mop_e;

  typedef struct packed {
    logic load;
    logic res_load;
    mop_e mop;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    chk_ok;
    logic    scan_hit;
    logic    scan_end;
    logic    shdn_end;
    logic    shup_end;
    logic    rev_more;
  } stat_t;

endpackage

>>> hdl/oale_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry store of the ordered array list engine. No dependencies.
`timescale 1ns / 1ps

module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/oale_ctrl.sv
// Controller state machine of the ordered array list engine.
// Sequences each action through the datapath and owns the stream handshakes.
// Depends on oale_pkg.
`timescale 1ns / 1ps

module oale_ctrl
  import oale_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_tvalid_i,
  output logic  s_tready_o,
  output logic  m_tvalid_o,
  input  logic  m_tready_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.chk_ok) begin
          state_d = S_RESULT;
        end else begin
          unique case (stat_i.act)
            ACT_REMOVE, ACT_READ, ACT_UPDATE, ACT_DEL_AT: state_d = S_FETCH;
            ACT_INSERT:                                   state_d = S_SHUP;
            ACT_SEARCH, ACT_DEL_VAL:                      state_d = S_SCAN;
            ACT_REVERSE:                                  state_d = S_REVB;
            default:                                      state_d = S_RESULT;
          endcase
        end
      end
      S_FETCH: begin
        state_d = (stat_i.act == ACT_DEL_AT) ? S_SHDN : S_RESULT;
      end
      S_SCAN: begin
        priority if (stat_i.scan_hit) begin
          state_d = (stat_i.act == ACT_DEL_VAL) ? S_SHDN : S_RESULT;
        end else if (stat_i.scan_end) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SHDN: begin
        if (stat_i.shdn_end) begin
          state_d = S_RESULT;
        end
      end
      S_SHUP: begin
        if (stat_i.shup_end) begin
          state_d = S_RESULT;
        end
      end
      S_REVB: state_d = S_REVC;
      S_REVC: state_d = S_REVD;
      S_REVD: begin
        state_d = stat_i.rev_more ? S_REVB : S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.res_load = 1'b0;
    cmd_o.mop      = MOP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      S_CHECK: cmd_o.mop = MOP_CHECK;
      S_FETCH: cmd_o.mop = MOP_FETCH;
      S_SCAN:  cmd_o.mop = MOP_SCAN;
      S_SHDN:  cmd_o.mop = MOP_SHDN;
      S_SHUP:  cmd_o.mop = MOP_SHUP;
      S_REVB:  cmd_o.mop = MOP_REVB;
      S_REVC:  cmd_o.mop = MOP_REVC;
      S_REVD:  cmd_o.mop = MOP_REVD;
      S_RESULT: begin
        cmd_o.mop      = MOP_RESULT;
        cmd_o.res_load = out_free;
      end
      default: cmd_o.mop = MOP_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.res_load) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign m_tvalid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

>>> hdl/oale_dp.sv
// Datapath of the ordered array list engine: item registers, walk pointers,
// entry RAM, range checks and the result register.
// Depends on oale_pkg and oale_ram.
`timescale 1ns / 1ps

module oale_dp
  import oale_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic [ACTION_W-1:0]      in_action_i,
  input  logic [POS_W-1:0]         in_position_i,
  input  logic signed [VAL_W-1:0]  in_value_i,
  output status_e                  out_status_o,
  output logic signed [VAL_W-1:0]  out_data_o,
  output logic [FIDX_W-1:0]        out_fidx_o,
  output logic [COUNT_W-1:0]       out_count_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  action_e                       act_q, act_d;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic signed [VALUE_BITS-1:0]  val_q, val_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [CNT_W-1:0]              ptr_q, ptr_d;
  logic [IDX_W-1:0]              prev_q, prev_d;
  logic [IDX_W-1:0]              hi_q, hi_d;
  logic [VALUE_BITS-1:0]         tmp_q, tmp_d;
  logic                          issued_q, issued_d;
  status_e                       status_q, status_d;
  logic signed [VAL_W-1:0]       data_q, data_d;
  logic [FIDX_W-1:0]             fidx_q, fidx_d;

  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [VALUE_BITS-1:0]         mem_wdata;
  logic [IDX_W-1:0]              mem_raddr;
  logic [VALUE_BITS-1:0]         mem_rdata;

  logic [CMP_W-1:0]              pos_x, cnt_x, ptr_x;
  logic                          is_full, is_empty;
  status_e                       chk_status;
  logic                          ptr_below_cnt;
  logic                          ptr_above_pos;

  oale_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign pos_x         = CMP_W'(pos_q);
  assign cnt_x         = CMP_W'(cnt_q);
  assign ptr_x         = CMP_W'(ptr_q);
  assign is_full       = (cnt_q == CNT_W'(DEPTH));
  assign is_empty      = (cnt_q == '0);
  assign ptr_below_cnt = (ptr_q < cnt_q);
  assign ptr_above_pos = (ptr_x > pos_x);

  always_comb begin
    chk_status = ST_OK;
    unique case (act_q)
      ACT_APPEND: begin
        if (is_full) chk_status = ST_FULL;
      end
      ACT_INSERT: begin
        priority if (is_full)     chk_status = ST_FULL;
        else if (pos_x > cnt_x)   chk_status = ST_BADPOS;
        else                      chk_status = ST_OK;
      end
      ACT_REMOVE, ACT_SEARCH, ACT_DEL_VAL: begin
        if (is_empty) chk_status = ST_EMPTY;
      end
      ACT_UPDATE, ACT_DEL_AT, ACT_READ: begin
        priority if (is_empty)    chk_status = ST_EMPTY;
        else if (pos_x >= cnt_x)  chk_status = ST_BADPOS;
        else                      chk_status = ST_OK;
      end
      ACT_REVERSE: begin
        if (cnt_q < CNT_W'(2)) chk_status = ST_TOOFEW;
      end
      default: chk_status = ST_OK;
    endcase
  end

  assign stat_o.act      = act_q;
  assign stat_o.chk_ok   = (chk_status == ST_OK);
  assign stat_o.scan_hit = issued_q && (mem_rdata == val_q);
  assign stat_o.scan_end = !issued_q && !ptr_below_cnt;
  assign stat_o.shdn_end = !issued_q && !ptr_below_cnt;
  assign stat_o.shup_end = !issued_q && !ptr_above_pos;
  assign stat_o.rev_more = ({1'b0, ptr_q} + (CNT_W + 1)'(2)) < (CNT_W + 1)'(hi_q);

  always_comb begin
    act_d     = act_q;
    pos_d     = pos_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    prev_d    = prev_q;
    hi_d      = hi_q;
    tmp_d     = tmp_q;
    issued_d  = issued_q;
    status_d  = status_q;
    data_d    = data_q;
    fidx_d    = fidx_q;
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(ptr_q);
    mem_wdata = val_q;
    mem_raddr = IDX_W'(ptr_q);

    if (cmd_i.load) begin
      act_d    = action_e'(in_action_i);
      pos_d    = in_position_i;
      val_d    = VALUE_BITS'(in_value_i);
      ptr_d    = '0;
      issued_d = 1'b0;
      status_d = ST_OK;
      data_d   = '0;
      fidx_d   = '0;
    end

    unique case (cmd_i.mop)
      MOP_CHECK: begin
        if (chk_status != ST_OK) begin
          status_d = chk_status;
        end else begin
          unique case (act_q)
            ACT_APPEND: begin
              mem_we    = 1'b1;
              mem_waddr = IDX_W'(cnt_q);
              cnt_d     = cnt_q + CNT_W'(1);
            end
            ACT_REMOVE: mem_raddr = IDX_W'(cnt_q - CNT_W'(1));
            ACT_READ, ACT_UPDATE, ACT_DEL_AT: mem_raddr = IDX_W'(pos_q);
            ACT_INSERT: ptr_d = cnt_q;
            ACT_CLEAR:  cnt_d = '0;
            ACT_REVERSE: hi_d = IDX_W'(cnt_q - CNT_W'(1));
            default: ;
          endcase
        end
      end
      MOP_FETCH: begin
        data_d = VAL_W'($signed(mem_rdata));
        unique case (act_q)
          ACT_REMOVE: cnt_d = cnt_q - CNT_W'(1);
          ACT_UPDATE: begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(pos_q);
          end
          ACT_DEL_AT: begin
            ptr_d    = CNT_W'(pos_q) + CNT_W'(1);
            issued_d = 1'b0;
          end
          default: ;
        endcase
      end
      MOP_SCAN: begin
        priority if (stat_o.scan_hit) begin
          if (act_q == ACT_SEARCH) begin
            fidx_d = FIDX_W'(prev_q);
          end else begin
            data_d   = VAL_W'(val_q);
            ptr_d    = CNT_W'(prev_q) + CNT_W'(1);
            issued_d = 1'b0;
          end
        end else if (stat_o.scan_end) begin
          status_d = ST_NOTFOUND;
        end else if (ptr_below_cnt) begin
          issued_d = 1'b1;
          prev_d   = IDX_W'(ptr_q);
          ptr_d    = ptr_q + CNT_W'(1);
        end else begin
          issued_d = 1'b0;
        end
      end
      MOP_SHDN: begin
        if (issued_q) begin
          mem_we    = 1'b1;
          mem_waddr = prev_q - IDX_W'(1);
          mem_wdata = mem_rdata;
        end
        if (ptr_below_cnt) begin
          issued_d = 1'b1;
          prev_d   = IDX_W'(ptr_q);
          ptr_d    = ptr_q + CNT_W'(1);
        end else begin
          issued_d = 1'b0;
        end
        if (stat_o.shdn_end) begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      MOP_SHUP: begin
        if (issued_q) begin
          mem_we    = 1'b1;
          mem_waddr = prev_q;
          mem_wdata = mem_rdata;
        end
        if (ptr_above_pos) begin
          mem_raddr = IDX_W'(ptr_q - CNT_W'(1));
          issued_d  = 1'b1;
          prev_d    = IDX_W'(ptr_q);
          ptr_d     = ptr_q - CNT_W'(1);
        end else begin
          issued_d = 1'b0;
        end
        if (stat_o.shup_end) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(pos_q);
          mem_wdata = val_q;
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      MOP_REVB: begin
        mem_raddr = hi_q;
        tmp_d     = mem_rdata;
      end
      MOP_REVC: begin
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(ptr_q);
        mem_wdata = mem_rdata;
      end
      MOP_REVD: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = tmp_q;
        mem_raddr = IDX_W'(ptr_q + CNT_W'(1));
        ptr_d     = ptr_q + CNT_W'(1);
        hi_d      = hi_q - IDX_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      issued_q <= 1'b0;
      act_q    <= ACT_APPEND;
    end else begin
      cnt_q    <= cnt_d;
      issued_q <= issued_d;
      act_q    <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    val_q    <= val_d;
    ptr_q    <= ptr_d;
    prev_q   <= prev_d;
    hi_q     <= hi_d;
    tmp_q    <= tmp_d;
    status_q <= status_d;
    data_q   <= data_d;
    fidx_q   <= fidx_d;
    if (cmd_i.res_load) begin
      out_status_o <= status_q;
      out_data_o   <= data_q;
      out_fidx_o   <= fidx_q;
      out_count_o  <= COUNT_W'(cnt_q);
    end
  end

endmodule

>>> hdl/ordered_array_list_engine_top.sv
// Top level of the ordered array list engine: controller, datapath and checks.
// Depends on oale_pkg, oale_ctrl, oale_dp and oale_ram.
//
//   Channel | Direction | tdata (low bit up)                      | tuser
//   s_axis  | in        | position, value, zero pad               | action
//   m_axis  | out       | data_out, found_index, entry_count, pad | status
//
// One item at a time, one RAM read and write port. Search walks the entries from
// index 0 until a match; insert, delete at and delete value shift the entries
// behind the position; reverse swaps pairs from both ends inward.
// Reset clears the count and the control state only. A result waits in the output
// register while the next item is accepted; a stalled output holds the one after.
`timescale 1ns / 1ps

module ordered_array_list_engine_top
  import oale_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // position[4:0], value[36:5], pad
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // action[3:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // data_out, found_index, entry_count, pad
  output logic [M_TUSER_W-1:0] m_axis_tuser   // status[2:0]
);

  cmd_t                    cmd;
  stat_t                   stat;
  status_e                 out_status;
  logic signed [VAL_W-1:0] out_data;
  logic [FIDX_W-1:0]       out_fidx;
  logic [COUNT_W-1:0]      out_count;

  oale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  oale_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_action_i   (s_axis_tuser[ACTION_W-1:0]),
    .in_position_i (s_axis_tdata[POS_W-1:0]),
    .in_value_i    ($signed(s_axis_tdata[POS_W +: VAL_W])),
    .out_status_o  (out_status),
    .out_data_o    (out_data),
    .out_fidx_o    (out_fidx),
    .out_count_o   (out_count)
  );

  assign m_axis_tdata = {(M_TDATA_W - VAL_W - FIDX_W - COUNT_W)'(0),
                         out_count, out_fidx, out_data};
  assign m_axis_tuser = out_status;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("Result loaded over an untaken result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !s_axis_tready)
    else $error("Input taken again before the item finished.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status != ST_OK) |-> (out_data == '0 && out_fidx == '0))
    else $error("Failed action carries a value or an index.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (DEPTH > 31 || 32'(out_count) <= 32'(DEPTH)))
    else $error("Entry count above the store depth.");
`endif

endmodule

>>> verif/ordered_array_list_engine_top_tb.sv
// Self-checking testbench of the ordered array list engine top level.
// A shadow list predicts each response, random gaps and stalls hit both stream sides.
// Depends on oale_pkg and ordered_array_list_engine_top.
`timescale 1ns / 1ps

module ordered_array_list_engine_top_tb;
  import oale_pkg::*;

  localparam int SLOTS       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_OPS  = 1100;

  typedef struct packed {
    status_e             status;
    logic [VAL_W-1:0]    data;
    logic [FIDX_W-1:0]   fidx;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  class list_mirror;
    logic [VAL_W-1:0] store [SLOTS];
    int unsigned      fill;
    list_result_t     expected_results [$];
    int               errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function bit find_first(input logic [VAL_W-1:0] val, output int unsigned idx);
      idx = 0;
      for (int unsigned i = 0; i < fill; i++) begin
        if (store[i] == val) begin
          idx = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void drop_entry(int unsigned at);
      for (int unsigned i = at; i + 1 < fill; i++) begin
        store[i] = store[i + 1];
      end
      fill--;
    endfunction

    function void note_request(action_e act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      list_result_t     r;
      int unsigned      idx;
      logic [VAL_W-1:0] tmp;
      r.status = ST_OK;
      r.data = '0;
      r.fidx = '0;
      case (act)
        ACT_APPEND: begin
          if (fill >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            store[fill] = val;
            fill++;
          end
        end
        ACT_INSERT: begin
          if (fill >= SLOTS) begin
            r.status = ST_FULL;
          end else if (pos > fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (int unsigned i = fill; i > pos; i--) begin
              store[i] = store[i - 1];
            end
            store[pos] = val;
            fill++;
          end
        end
        ACT_REMOVE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            fill--;
            r.data = store[fill];
          end
        end
        ACT_SEARCH: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (find_first(val, idx)) begin
            r.fidx = FIDX_W'(idx);
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
        ACT_UPDATE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            r.data = store[pos];
            store[pos] = val;
          end
        end
        ACT_DEL_VAL: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (find_first(val, idx)) begin
            r.data = store[idx];
            drop_entry(idx);
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
        ACT_DEL_AT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            r.data = store[pos];
            drop_entry(pos);
          end
        end
        ACT_CLEAR: begin
          fill = 0;
        end
        ACT_REVERSE: begin
          if (fill < 2) begin
            r.status = ST_TOOFEW;
          end else begin
            for (int unsigned i = 0; i < fill / 2; i++) begin
              tmp = store[i];
              store[i] = store[fill - 1 - i];
              store[fill - 1 - i] = tmp;
            end
          end
        end
        ACT_READ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            r.data = store[pos];
          end
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'(fill);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      list_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d tdata %h", $time, tuser, tdata);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (tuser !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, tuser);
        errors++;
      end
      if (tdata[31:0] !== want.data) begin
        $display("%0t: data_out expected %h actual %h", $time, want.data, tdata[31:0]);
        errors++;
      end
      if (tdata[35:32] !== want.fidx) begin
        $display("%0t: found_index expected %0d actual %0d", $time, want.fidx, tdata[35:32]);
        errors++;
      end
      if (tdata[40:36] !== want.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, want.count, tdata[40:36]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  list_mirror  book = new();
  int unsigned cycle_count = 0;
  int          send_calm = 0;
  int          recv_calm = 0;

  ordered_array_list_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      book.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic send_op(action_e act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, val, pos};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    book.note_request(act, pos, val);
  endtask

  initial begin
    int gap;
    forever begin
      gap = draw_wait(recv_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    action_e          act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned      grow;
    int unsigned      r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(ACT_REMOVE, 5'd0, 32'h0);
    send_op(ACT_READ, 5'd16, 32'hFFFF_FFFF);
    send_op(ACT_APPEND, 5'd0, 32'h7FFF_FFFF);
    send_op(ACT_REVERSE, 5'd0, 32'h0);
    for (int i = 1; i < SLOTS; i++) begin
      case (i)
        1:       val = 32'h8000_0000;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        4:       val = 32'h5555_5555;
        5:       val = 32'hAAAA_AAAA;
        default: val = $urandom();
      endcase
      pos = (i % 3 == 0) ? 5'd0 : (i % 3 == 1) ? POS_W'(i) : POS_W'(i / 2);
      send_op(ACT_INSERT, pos, val);
    end
    send_op(ACT_APPEND, 5'd0, 32'h1234_5678);
    send_op(ACT_INSERT, 5'd16, 32'h1);
    send_op(ACT_SEARCH, 5'd0, 32'hAAAA_AAAA);
    send_op(ACT_READ, 5'd16, 32'h0);
    send_op(ACT_DEL_AT, 5'd15, 32'h0);
    send_op(ACT_REVERSE, 5'd0, 32'h0);
    send_op(ACT_CLEAR, 5'd31, 32'hFFFF_FFFF);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      grow = (book.fill < 8) ? 55 : (book.fill >= 14) ? 20 : 35;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        act = ACT_CLEAR;
      end else if (r < 2 + grow) begin
        act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
      end else begin
        case ($urandom_range(0, 6))
          0:       act = ACT_REMOVE;
          1:       act = ACT_SEARCH;
          2:       act = ACT_UPDATE;
          3:       act = ACT_DEL_VAL;
          4:       act = ACT_DEL_AT;
          5:       act = ACT_REVERSE;
          default: act = ACT_READ;
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        pos = POS_W'($urandom_range(0, 16));
      end else if (act == ACT_INSERT) begin
        pos = POS_W'($urandom_range(0, book.fill));
      end else begin
        pos = (book.fill > 0) ? POS_W'($urandom_range(0, book.fill - 1)) : 5'd0;
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
        val = $urandom_range(0, 6) - 3;
      end else if (r < 6 && book.fill > 0) begin
        val = book.store[$urandom_range(0, book.fill - 1)];
      end else if (r == 6) begin
        val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        val = $urandom();
      end
      send_op(act, pos, val);
    end
    s_axis_tvalid <= 1'b0;

    while (book.expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (book.errors == 0 && book.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
